/* rtl/rtcbcd_pkg.sv */
// Package for the RTC date and time to BCD register encoder.
// Holds the word types of both channels, the pipeline depth and the BCD
// and month length helpers. Depends on nothing.
package rtcbcd_pkg;

    // Number of register stages from input word to output word.
    localparam int unsigned PIPE_STAGES = 4;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_FEB   = 5'd28;

    typedef struct packed {
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] full_year;
    } t_rtc_in;

    typedef struct packed {
        logic [6:0] second_reg;
        logic [6:0] minute_reg;
        logic [5:0] hour_reg;
        logic [5:0] day_reg;
        logic [2:0] weekday_reg;
        logic [7:0] month_century_reg;
        logic [7:0] year_reg;
    } t_rtc_out;

    // Two-digit BCD of a value below 100. The tens digit comes from a
    // multiplication by 103/1024, which is exact over that range.
    function automatic logic [7:0] to_bcd(input logic [6:0] value);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 14'(value) * 14'd103;
        tens = prod[13:10];
        ones = value - 7'(7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    // Length of a common-year month; anything outside 1..12 counts as 31.
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] days;
        case (month)
            MONTH_FEB: begin
                days = DAYS_FEB;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                days = DAYS_SHORT;
            end
            default: begin
                days = DAYS_LONG;
            end
        endcase
        return days;
    endfunction

endpackage

/* rtl/rtcbcd_flow.sv */
// Valid and stall control for the encoder pipeline.
// Keeps one valid bit per stage and gives each stage its load enable.
// Depends on nothing; the stage count comes in as a parameter.
module rtcbcd_flow #(
    parameter int unsigned Stages = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [Stages-1:0] o_load
);

    logic [Stages-1:0] r_valid;
    logic [Stages-1:0] n_valid;

    // A stage may load when it is empty or when its word moves on.
    always_comb begin
        o_load[Stages-1] = !r_valid[Stages-1] || !i_stall;
        for (int k = int'(Stages) - 2; k >= 0; k--) begin
            o_load[k] = !r_valid[k] || o_load[k+1];
        end
    end

    always_comb begin
        n_valid[0] = o_load[0] ? i_valid : r_valid[0];
        for (int k = 1; k < int'(Stages); k++) begin
            n_valid[k] = o_load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !o_load[0];
    assign o_valid = r_valid[Stages-1];

endmodule

/* rtl/rtc_datetime_to_bcd_registers.sv */
// Top level of the RTC date and time to BCD register encoder.
// Uses rtcbcd_pkg for word types and helpers, and rtcbcd_flow for control.
// An accepted input word is registered in r_s1, r_s2, r_s3 and r_out in turn.
// Throughput: one word per cycle while no stall holds the pipeline; the four stages are fully pipelined.
// Stall from the output side holds every full stage and backs up to o_stall.
// Reset (synchronous, active low) empties all stages; the data registers are not reset.
module rtc_datetime_to_bcd_registers (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rtcbcd_pkg::t_rtc_in   i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output rtcbcd_pkg::t_rtc_out  o_data,
    input  logic                  i_stall
);

    import rtcbcd_pkg::*;

    // Field limits and year window.
    localparam logic [5:0]  SEC_LIMIT   = 6'd60;
    localparam logic [4:0]  HOUR_LIMIT  = 5'd24;
    localparam logic [11:0] YEAR_2100   = 12'd2100;
    localparam logic [11:0] YEAR_2000   = 12'd2000;
    localparam logic [11:0] YEAR_1900   = 12'd1900;
    localparam logic [6:0]  YEAR_TOP    = 7'd99;
    localparam logic [11:0] CENTURY_LEN = 12'd100;

    // Reciprocal multipliers for the constant divisions.
    // Divide by 100: multiply by 1311 and drop 17 bits (exact below 4096).
    // Divide by 5: multiply by 13 and drop 6 bits (exact below 64).
    // Divide by 7: multiply by 37450 and drop 18 bits (exact below 8192).
    localparam logic [10:0] MUL_DIV100 = 11'd1311;
    localparam logic [3:0]  MUL_DIV5   = 4'd13;
    localparam logic [15:0] MUL_DIV7   = 16'd37450;
    localparam logic [12:0] WEEK_LEN   = 13'd7;

    // Stage one: clamped time fields, year window, weekday inputs and the
    // two division products by 100.
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hr;
        logic [4:0]  day;
        logic [3:0]  mon;
        logic [11:0] year;
        logic [6:0]  year_off;
        logic        cent;
        logic [3:0]  mon_w;
        logic        year_neg;
        logic [11:0] year_w;
        logic [22:0] prod_y;
        logic [22:0] prod_w;
    } t_stage1;

    // Stage two: BCD of the simple fields, leap flag and the weekday sum.
    typedef struct packed {
        logic [6:0]  sec_bcd;
        logic [6:0]  min_bcd;
        logic [5:0]  hr_bcd;
        logic [7:0]  year_bcd;
        logic        cent;
        logic [6:0]  mon_bcd;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic        leap;
        logic [12:0] wsum;
    } t_stage2;

    // Stage three: day clamped and encoded, weekday sum times 1/7.
    typedef struct packed {
        logic [6:0]  sec_bcd;
        logic [6:0]  min_bcd;
        logic [5:0]  hr_bcd;
        logic [5:0]  day_bcd;
        logic [7:0]  month_cent;
        logic [7:0]  year_bcd;
        logic [12:0] wsum;
        logic [28:0] prod_s;
    } t_stage3;

    logic [PIPE_STAGES-1:0] w_load;

    t_stage1  r_s1, n_s1;
    t_stage2  r_s2, n_s2;
    t_stage3  r_s3, n_s3;
    t_rtc_out r_out, n_out;

    // Stage two helpers.
    logic [5:0]  w_q_year;
    logic [6:0]  w_rem_year;
    logic [5:0]  w_q_wyear;
    logic [5:0]  w_mon_term;
    logic [9:0]  w_mon_prod;
    logic [12:0] w_year_part;

    // Stage three helpers.
    logic [4:0]  w_mon_len;
    logic [4:0]  w_day_sel;

    // Stage four helper.
    logic [10:0] w_q_week;

    rtcbcd_flow #(
        .Stages (PIPE_STAGES)
    ) u_flow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_load  (w_load)
    );

    // Stage one. Out-of-range time fields fold to zero, the year is placed
    // in its century window, and January and February count as months 13
    // and 14 of the previous year for the weekday.
    always_comb begin
        logic adj_month;
        n_s1.sec  = (i_data.seconds < SEC_LIMIT) ? i_data.seconds : '0;
        n_s1.min  = (i_data.minutes < SEC_LIMIT) ? i_data.minutes : '0;
        n_s1.hr   = (i_data.hours < HOUR_LIMIT) ? i_data.hours : '0;
        n_s1.day  = i_data.day_of_month;
        n_s1.mon  = i_data.month_number;
        n_s1.year = i_data.full_year;

        if (i_data.full_year >= YEAR_2100) begin
            n_s1.year_off = YEAR_TOP;
            n_s1.cent     = 1'b0;
        end else if (i_data.full_year >= YEAR_2000) begin
            n_s1.year_off = 7'(i_data.full_year - YEAR_2000);
            n_s1.cent     = 1'b0;
        end else if (i_data.full_year >= YEAR_1900) begin
            n_s1.year_off = 7'(i_data.full_year - YEAR_1900);
            n_s1.cent     = 1'b1;
        end else begin
            n_s1.year_off = '0;
            n_s1.cent     = 1'b1;
        end

        adj_month = (i_data.month_number == MONTH_JAN) ||
                    (i_data.month_number == MONTH_FEB);
        n_s1.mon_w    = adj_month ? i_data.month_number + 4'd12 : i_data.month_number;
        n_s1.year_neg = adj_month && (i_data.full_year == '0);
        n_s1.year_w   = adj_month ? i_data.full_year - 12'd1 : i_data.full_year;

        n_s1.prod_y = 23'(i_data.full_year) * 23'(MUL_DIV100);
        n_s1.prod_w = 23'(n_s1.year_w) * 23'(MUL_DIV100);
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_s1 <= n_s1;
        end
    end

    // Stage two. The leap rule uses the year's quotient and remainder by
    // 100. The weekday sum adds the day, twice the month, the month term
    // 3(m+1)/5 and the year terms y + y/4 - y/100 + y/400 + 1. When the
    // adjusted year is minus one (year zero in January or February) all
    // year divisions truncate to zero, so the year terms cancel to zero.
    always_comb begin
        w_q_year   = r_s1.prod_y[22:17];
        w_rem_year = 7'(r_s1.year - 12'(12'(w_q_year) * CENTURY_LEN));
        w_q_wyear  = r_s1.prod_w[22:17];
        w_mon_term = 6'(6'({2'b00, r_s1.mon_w} + 6'd1) * 6'd3);
        w_mon_prod = 10'(w_mon_term) * 10'(MUL_DIV5);

        if (r_s1.year_neg) begin
            w_year_part = '0;
        end else begin
            w_year_part = 13'(r_s1.year_w) + 13'(r_s1.year_w[11:2]) -
                          13'(w_q_wyear) + 13'(w_q_wyear[5:2]) + 13'd1;
        end

        n_s2.sec_bcd  = 7'(to_bcd({1'b0, r_s1.sec}));
        n_s2.min_bcd  = 7'(to_bcd({1'b0, r_s1.min}));
        n_s2.hr_bcd   = 6'(to_bcd({2'b00, r_s1.hr}));
        n_s2.year_bcd = to_bcd(r_s1.year_off);
        n_s2.cent     = r_s1.cent;
        n_s2.mon_bcd  = 7'(to_bcd({3'b000, r_s1.mon}));
        n_s2.mon      = r_s1.mon;
        n_s2.day      = r_s1.day;
        n_s2.leap     = ((r_s1.year[1:0] == 2'b00) && (w_rem_year != '0)) ||
                        ((w_rem_year == '0) && (w_q_year[1:0] == 2'b00));
        n_s2.wsum     = 13'(r_s1.day) + 13'({r_s1.mon_w, 1'b0}) +
                        13'(w_mon_prod[9:6]) + w_year_part;
    end

    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r_s2 <= n_s2;
        end
    end

    // Stage three. The day is clamped to the month length and a zero day
    // becomes the first; the weekday sum is multiplied toward its /7.
    always_comb begin
        w_mon_len = month_days(r_s2.mon) +
                    5'((r_s2.mon == MONTH_FEB) && r_s2.leap);
        if (r_s2.day > w_mon_len) begin
            w_day_sel = w_mon_len;
        end else if (r_s2.day != '0) begin
            w_day_sel = r_s2.day;
        end else begin
            w_day_sel = 5'd1;
        end

        n_s3.sec_bcd    = r_s2.sec_bcd;
        n_s3.min_bcd    = r_s2.min_bcd;
        n_s3.hr_bcd     = r_s2.hr_bcd;
        n_s3.day_bcd    = 6'(to_bcd({2'b00, w_day_sel}));
        n_s3.month_cent = {r_s2.cent, r_s2.mon_bcd};
        n_s3.year_bcd   = r_s2.year_bcd;
        n_s3.wsum       = r_s2.wsum;
        n_s3.prod_s     = 29'(r_s2.wsum) * 29'(MUL_DIV7);
    end

    always_ff @(posedge i_clk) begin
        if (w_load[2]) begin
            r_s3 <= n_s3;
        end
    end

    // Stage four. The weekday is the remainder of the sum by seven, and
    // the output word is assembled into its register.
    always_comb begin
        w_q_week = r_s3.prod_s[28:18];

        n_out.second_reg        = r_s3.sec_bcd;
        n_out.minute_reg        = r_s3.min_bcd;
        n_out.hour_reg          = r_s3.hr_bcd;
        n_out.day_reg           = r_s3.day_bcd;
        n_out.weekday_reg       = 3'(r_s3.wsum - 13'(13'(w_q_week) * WEEK_LEN));
        n_out.month_century_reg = r_s3.month_cent;
        n_out.year_reg          = r_s3.year_bcd;
    end

    always_ff @(posedge i_clk) begin
        if (w_load[3]) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

/* rtl/rtcbcd_checker.sv */
// Port-level checks for the RTC date and time to BCD register encoder.
// Uses rtcbcd_pkg for the output word type; bound to the top level below.
module rtcbcd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input rtcbcd_pkg::t_rtc_out o_data
);

    import rtcbcd_pkg::*;

    // A stalled output word stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output word changed or dropped while stalled");

    // The weekday is always a remainder by seven.
    a_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.weekday_reg <= 3'd6)
        else $error("weekday out of range");

    // The ones digit of every BCD field and both year digits are decimal digits.
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.second_reg[3:0] <= 4'd9) &&
                    (o_data.minute_reg[3:0] <= 4'd9) &&
                    (o_data.hour_reg[3:0] <= 4'd9) &&
                    (o_data.day_reg[3:0] <= 4'd9) &&
                    (o_data.year_reg[3:0] <= 4'd9) &&
                    (o_data.year_reg[7:4] <= 4'd9) &&
                    (o_data.month_century_reg[3:0] <= 4'd9))
        else $error("output holds a non-decimal BCD digit");

    // The day register is a clamped day, never zero and never past 31.
    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.day_reg != 6'h00) && (o_data.day_reg <= 6'h31))
        else $error("day register outside 1..31");

endmodule

bind rtc_datetime_to_bcd_registers rtcbcd_checker u_rtcbcd_checker (.*);

/* dv/rtc_datetime_to_bcd_registers_test.sv */
// Self-checking testbench for rtc_datetime_to_bcd_registers.
// Drives binary dates through the valid/stall input channel and checks every BCD
// register word that comes out against its own encoder. Depends on rtcbcd_pkg and the RTL.
module rtc_datetime_to_bcd_registers_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcbcd_pkg::*;

    // The slowest correct run is roughly 475 words times (the longest idle gap on the
    // input side + the longest stall on the output side + pipeline depth), so this
    // limit leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned RANDOM_DATES = 450;
    localparam int unsigned MAX_REPORTS = 10;

    // A date waiting to be sent. When hold_until_drained is set, the sender
    // keeps its valid low until every word in flight has been checked.
    typedef struct {
        t_rtc_in date;
        bit      hold_until_drained;
    } t_pending_date;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_rtc_in  i_data = '0;
    logic     o_stall;
    logic     o_valid;
    t_rtc_out o_data;
    logic     i_stall = 1'b0;

    t_pending_date pending_dates[$];
    t_rtc_out      expected_regs[$];

    int unsigned cycle_count = 0;
    int unsigned dates_queued = 0;
    int unsigned dates_sent = 0;
    int unsigned words_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned century_dates = 0;
    int unsigned odd_dates = 0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          stall_left = 0;
    int          stall_calm = 0;

    rtc_datetime_to_bcd_registers dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Two-digit packed BCD of a binary value.
    function automatic int unsigned bcd2(input int unsigned value);
        return ((value / 10) << 4) + (value % 10);
    endfunction

    // Gregorian leap rule applied to the year exactly as it arrives.
    function automatic bit is_leap(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    // Days in the month; months outside 1..12 are treated as 31 days long.
    function automatic int unsigned days_in_month(input int unsigned month,
                                                  input int unsigned year);
        int unsigned days;
        case (month)
            2: days = is_leap(year) ? 29 : 28;
            4, 6, 9, 11: days = 30;
            default: days = 31;
        endcase
        return days;
    endfunction

    // Encodes one binary date into the seven RTC register fields.
    function automatic t_rtc_out encode_rtc_regs(input t_rtc_in date);
        t_rtc_out    regs;
        int unsigned month_len;
        int unsigned day_used;
        int unsigned year_bcd;
        int unsigned century;
        int          wy;
        int          wm;
        int          wsum;
        month_len = days_in_month(date.month_number, date.full_year);
        if (date.day_of_month > month_len) begin
            day_used = month_len;
        end else if (date.day_of_month > 0) begin
            day_used = date.day_of_month;
        end else begin
            day_used = 1;
        end
        // Years are pinned to 1900..2099; everything before 2000 flags the
        // 19xx century in bit 7 of the month register.
        if (date.full_year >= 2100) begin
            year_bcd = bcd2(99);
            century = 0;
        end else if (date.full_year >= 2000) begin
            year_bcd = bcd2(date.full_year - 2000);
            century = 0;
        end else if (date.full_year >= 1900) begin
            year_bcd = bcd2(date.full_year - 1900);
            century = 'h80;
        end else begin
            year_bcd = 0;
            century = 'h80;
        end
        // Zeller-style weekday on the unclamped fields. January and February
        // count as months 13 and 14 of the year before; signed division
        // truncates toward zero, which matters only for year 0.
        wy = int'(date.full_year);
        wm = int'(date.month_number);
        if (wm == 1 || wm == 2) begin
            wm = wm + 12;
            wy = wy - 1;
        end
        wsum = int'(date.day_of_month) + 2 * wm + (3 * (wm + 1)) / 5
             + wy + wy / 4 - wy / 100 + wy / 400 + 1;
        regs.second_reg = 7'(bcd2(date.seconds < 60 ? date.seconds : 0));
        regs.minute_reg = 7'(bcd2(date.minutes < 60 ? date.minutes : 0));
        regs.hour_reg = 6'(bcd2(date.hours < 24 ? date.hours : 0));
        regs.day_reg = 6'(bcd2(day_used));
        regs.weekday_reg = 3'(wsum % 7);
        regs.month_century_reg = 8'(century | (bcd2(date.month_number) & 'h7F));
        regs.year_reg = 8'(year_bcd);
        return regs;
    endfunction

    // Idle cycles before the next word on one side. Now and then a calm
    // stretch starts in which that side does not idle at all.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic add_date(input int unsigned sec, input int unsigned min,
                            input int unsigned hr, input int unsigned day,
                            input int unsigned mon, input int unsigned yr,
                            input bit drain);
        t_pending_date item;
        item.date.seconds = 6'(sec);
        item.date.minutes = 6'(min);
        item.date.hours = 5'(hr);
        item.date.day_of_month = 5'(day);
        item.date.month_number = 4'(mon);
        item.date.full_year = 12'(yr);
        item.hold_until_drained = drain;
        if (yr < 2000) begin
            century_dates++;
        end
        if (mon < 1 || mon > 12 || yr < 1900 || yr >= 2100) begin
            odd_dates++;
        end
        pending_dates.push_back(item);
        dates_queued++;
    endtask

    // Reset is held at the start and never asserted again.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Input side. A word moves when valid is high and o_stall is low at the
    // edge; while stalled, the word and its valid are held unchanged. Each new
    // word only goes out once its drawn idle gap has run down.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                expected_regs.push_back(encode_rtc_regs(i_data));
                dates_sent++;
            end
            if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_dates.size() > 0 &&
                         !(pending_dates[0].hold_until_drained && expected_regs.size() > 0)) begin
                i_valid <= 1'b1;
                i_data <= pending_dates[0].date;
                send_gap <= draw_wait(send_calm);
                pending_dates.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output side. Every accepted word is compared field by field with the
    // oldest expectation. After each accepted word the receiver draws how
    // long it holds i_stall high before it takes the next one.
    always @(posedge i_clk) begin
        t_rtc_out want;
        int       hold;
        hold = stall_left;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid === 1'b1 && !i_stall) begin
                if (expected_regs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0d] output word with no date pending: %h",
                                 cycle_count, o_data);
                    end
                end else begin
                    want = expected_regs.pop_front();
                    words_checked++;
                    if (o_data.second_reg !== want.second_reg ||
                        o_data.minute_reg !== want.minute_reg ||
                        o_data.hour_reg !== want.hour_reg ||
                        o_data.day_reg !== want.day_reg ||
                        o_data.weekday_reg !== want.weekday_reg ||
                        o_data.month_century_reg !== want.month_century_reg ||
                        o_data.year_reg !== want.year_reg) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            // Fields in order: sec, min, hr, day, weekday, month, year.
                            $display("[%0d] word %0d expected %h %h %h %h %h %h %h",
                                     cycle_count, words_checked,
                                     want.second_reg, want.minute_reg, want.hour_reg,
                                     want.day_reg, want.weekday_reg,
                                     want.month_century_reg, want.year_reg);
                            $display("[%0d] word %0d got      %h %h %h %h %h %h %h",
                                     cycle_count, words_checked,
                                     o_data.second_reg, o_data.minute_reg,
                                     o_data.hour_reg, o_data.day_reg, o_data.weekday_reg,
                                     o_data.month_century_reg, o_data.year_reg);
                        end
                    end
                end
                hold = draw_wait(stall_calm);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                stall_left <= hold - 1;
            end else begin
                i_stall <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words still expected",
                     cycle_count, expected_regs.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned sec;
        int unsigned min;
        int unsigned hr;
        int unsigned day;
        int unsigned mon;
        int unsigned yr;
        bit          drain;

        // Directed dates: field extremes, the range limits of seconds, minutes
        // and hours, the leap rules, day clamping, months outside 1..12 and
        // years on both sides of the 1900..2099 window.
        add_date(0, 0, 0, 0, 1, 0, 1'b0);        // all zero, year 0 in January
        add_date(63, 63, 31, 31, 15, 4095, 1'b0); // every field at its maximum
        add_date(59, 59, 23, 31, 12, 2099, 1'b0); // last valid instant
        add_date(60, 60, 24, 1, 6, 2018, 1'b0);   // just past the time limits
        add_date(0, 0, 0, 29, 2, 2000, 1'b0);     // leap by the 400-year rule
        add_date(0, 0, 0, 29, 2, 1900, 1'b0);     // not leap by the 100-year rule
        add_date(30, 30, 12, 29, 2, 2024, 1'b0);
        add_date(1, 2, 3, 31, 2, 2023, 1'b0);     // February clamp, common year
        add_date(5, 6, 7, 31, 4, 2010, 1'b0);     // 30-day month clamp
        add_date(45, 15, 9, 0, 7, 2050, 1'b0);    // day 0 becomes 1
        add_date(12, 34, 5, 15, 3, 1899, 1'b0);   // below the century window
        add_date(0, 0, 0, 1, 1, 1900, 1'b0);
        add_date(59, 59, 23, 31, 12, 1999, 1'b0);
        add_date(0, 0, 0, 1, 1, 2000, 1'b0);
        add_date(7, 8, 9, 1, 3, 2100, 1'b0);      // above the century window
        add_date(10, 10, 10, 10, 0, 2020, 1'b0);  // month 0
        add_date(3, 3, 3, 31, 13, 2021, 1'b0);    // month 13
        add_date(0, 0, 0, 29, 2, 0, 1'b0);        // year 0 in February
        add_date(0, 0, 0, 29, 2, 4095, 1'b0);
        add_date(1, 1, 1, 1, 1, 1, 1'b0);
        add_date(0, 0, 0, 29, 2, 2096, 1'b0);
        add_date(0, 0, 0, 29, 2, 2100, 1'b0);

        // Random dates: mostly plausible calendar values around the century
        // window, with a share of words that take any value the fields allow.
        for (int unsigned n = 0; n < RANDOM_DATES; n++) begin
            pick = $urandom_range(0, 9);
            drain = (n == 0 || n == 150 || n == 300);
            if (pick < 2) begin
                sec = $urandom_range(0, 63);
                min = $urandom_range(0, 63);
                hr = $urandom_range(0, 31);
                day = $urandom_range(0, 31);
                mon = $urandom_range(0, 15);
                yr = $urandom_range(0, 4095);
            end else begin
                sec = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
                min = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
                hr = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
                day = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 31);
                mon = $urandom_range(1, 12);
                yr = $urandom_range(1880, 2120);
            end
            add_date(sec, min, hr, day, mon, yr, drain);
        end

        // Wait until every queued date has come back as a checked word, then run on
        // past the pipeline depth to expose stray output words.
        while (words_checked < dates_queued) begin
            @(posedge i_clk);
        end
        repeat (PIPE_STAGES + 8) @(posedge i_clk);

        $display("Sent %0d dates (%0d before 2000, %0d outside the normal month or year range)",
                 dates_sent, century_dates, odd_dates);
        $display("Checked %0d register words, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0 && expected_regs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* rtc_datetime_to_bcd_registers.f */
rtl/rtcbcd_pkg.sv
rtl/rtcbcd_flow.sv
rtl/rtc_datetime_to_bcd_registers.sv
rtl/rtcbcd_checker.sv
dv/rtc_datetime_to_bcd_registers_test.sv
